/* rtl/tfrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfrd_pkg
// Shared types and constants of the tagged frame receive deframer.
// ----------------------------------------------------------------------------
package tfrd_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_RX_BYTE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  // frame tracker phase
  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_TAG_HDR  = 2'd1,
    PH_TAG_DATA = 2'd2,
    PH_LAST_DATA = 2'd3
  } phase_e;

  // tracker events reported with each result
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_HDR_OK     = 3'd1,
    EV_HDR_BAD    = 3'd2,
    EV_TAG_START  = 3'd3,
    EV_ZERO_LEN   = 3'd4,
    EV_TAG_DONE   = 3'd5,
    EV_FRAME_DONE = 3'd6
  } event_e;

  // header signature bytes
  localparam logic [7:0] HDR_BYTE0 = 8'h4E;
  localparam logic [7:0] HDR_BYTE1 = 8'h52;
  localparam logic [7:0] HDR_BYTE2 = 8'h50;

  // last-tag marker bit in the tag byte
  localparam int unsigned LAST_TAG_BIT = 7;

  // fill level saturation
  localparam logic [7:0] FILL_MAX = 8'hFF;

  // control from the top level to the tracker
  typedef struct packed {
    logic byte_en;
    logic restart;
  } trk_ctl_t;

  // tracker result for the current transaction
  typedef struct packed {
    phase_e phase;
    event_e evt;
  } trk_out_t;

endpackage
`default_nettype wire

/* rtl/tfrd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfrd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/tfrd_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfrd_tracker
// Frame tracker: header block hunt, tag header parse and data countdown.
// ----------------------------------------------------------------------------
module tfrd_tracker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         byte_i,
  input  wire tfrd_pkg::trk_ctl_t ctl_i,
  output tfrd_pkg::trk_out_t      out_o
);

  tfrd_pkg::phase_e phase_q, phase_d;
  logic [1:0]       pos_q, pos_d;
  logic             match_q, match_d;
  logic             last_q, last_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [15:0]      rem_q, rem_d;
  tfrd_pkg::event_e evt;
  logic [15:0]      len;
  logic [15:0]      rem_dec;

  assign len     = {len_hi_q, byte_i};
  assign rem_dec = rem_q - 16'd1;

  // next tracker state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    match_d  = match_q;
    last_d   = last_q;
    len_hi_d = len_hi_q;
    rem_d    = rem_q;
    evt      = tfrd_pkg::EV_NONE;
    if (ctl_i.restart) begin
      phase_d = tfrd_pkg::PH_HUNT;
      pos_d   = 2'd0;
      match_d = 1'b1;
      rem_d   = 16'd0;
    end else if (ctl_i.byte_en) begin
      unique case (phase_q)
        tfrd_pkg::PH_HUNT: begin
          unique case (pos_q)
            2'd0: begin
              if (byte_i != tfrd_pkg::HDR_BYTE0) match_d = 1'b0;
              pos_d = 2'd1;
            end
            2'd1: begin
              if (byte_i != tfrd_pkg::HDR_BYTE1) match_d = 1'b0;
              pos_d = 2'd2;
            end
            2'd2: begin
              if (byte_i != tfrd_pkg::HDR_BYTE2) match_d = 1'b0;
              pos_d = 2'd3;
            end
            default: begin
              // fourth byte closes the block
              if (match_q) begin
                phase_d = tfrd_pkg::PH_TAG_HDR;
                evt     = tfrd_pkg::EV_HDR_OK;
              end else begin
                evt = tfrd_pkg::EV_HDR_BAD;
              end
              pos_d   = 2'd0;
              match_d = 1'b1;
            end
          endcase
        end
        tfrd_pkg::PH_TAG_HDR: begin
          priority if (pos_q == 2'd0) begin
            last_d = byte_i[tfrd_pkg::LAST_TAG_BIT];
            pos_d  = 2'd1;
          end else if (pos_q == 2'd1) begin
            len_hi_d = byte_i;
            pos_d    = 2'd2;
          end else begin
            pos_d = 2'd0;
            if (len == 16'd0) begin
              phase_d = tfrd_pkg::PH_HUNT;
              match_d = 1'b1;
              evt     = tfrd_pkg::EV_ZERO_LEN;
            end else begin
              rem_d   = len;
              phase_d = last_q ? tfrd_pkg::PH_LAST_DATA : tfrd_pkg::PH_TAG_DATA;
              evt     = tfrd_pkg::EV_TAG_START;
            end
          end
        end
        default: begin
          // data countdown
          rem_d = rem_dec;
          if (rem_dec == 16'd0) begin
            pos_d   = 2'd0;
            match_d = 1'b1;
            if (phase_q == tfrd_pkg::PH_LAST_DATA) begin
              phase_d = tfrd_pkg::PH_HUNT;
              evt     = tfrd_pkg::EV_FRAME_DONE;
            end else begin
              phase_d = tfrd_pkg::PH_TAG_HDR;
              evt     = tfrd_pkg::EV_TAG_DONE;
            end
          end
        end
      endcase
    end
  end

  // tracker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tfrd_pkg::PH_HUNT;
      pos_q    <= 2'd0;
      match_q  <= 1'b1;
      last_q   <= 1'b0;
      len_hi_q <= 8'd0;
      rem_q    <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      match_q  <= match_d;
      last_q   <= last_d;
      len_hi_q <= len_hi_d;
      rem_q    <= rem_d;
    end
  end

  // result for this transaction
  assign out_o.phase = phase_d;
  assign out_o.evt   = evt;

endmodule
`default_nettype wire

/* rtl/tagged_frame_rx_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_frame_rx_deframer
// Receive ring buffer with a tagged frame tracker.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one transaction per item:
// a received byte, a host read or a frame hunt restart. Good bytes are
// written into the ring RAM and fed to the frame tracker; a byte with a line
// error is discarded and sets a sticky error that the next host read clears.
// A good byte that finds the ring full (RING_DEPTH-1 bytes) is dropped and
// flagged as overflow.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// input transaction, in order: popped byte, tracker phase and event, fill
// level (saturated at 255), sticky error before the item, overflow.
// The result appears in the cycle after the item is accepted, in the output
// register with the ring RAM's registered read data. Throughput is one item
// per cycle unless the receiver stalls, set by the single read-modify-write
// of the ring indexes and tracker state. During a stall the output register
// holds and the input is taken again in the cycle the result is consumed.
// Reset clears indexes, fill count, tracker and sticky error; ring contents
// are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module tagged_frame_rx_deframer #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       line_error_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] read_data_o,
  output logic            read_valid_o,
  output logic      [1:0] frame_phase_o,
  output logic      [2:0] frame_event_o,
  output logic      [7:0] fill_level_o,
  output logic            error_seen_o,
  output logic            overflow_o
);

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             sticky_q, sticky_d;
  logic             accept;
  logic             full, empty;
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic             ovf;
  logic [16:0]      cnt_ext;
  logic [7:0]       fill_sat;
  tfrd_pkg::kind_e  kind;
  tfrd_pkg::trk_ctl_t trk_ctl;
  tfrd_pkg::trk_out_t trk_out;

  // output register
  logic             out_valid_q;
  logic             rvalid_q;
  logic [1:0]       phase_q;
  logic [2:0]       event_q;
  logic [7:0]       fill_q;
  logic             err_q;
  logic             ovf_q;

  assign kind   = tfrd_pkg::kind_e'(kind_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign full   = (cnt_q == IDX_W'(RING_DEPTH - 1));
  assign empty  = (cnt_q == '0);

  // ring control for this transaction
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ovf      = 1'b0;
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    cnt_d    = cnt_q;
    sticky_d = sticky_q;
    trk_ctl  = '0;
    if (accept) begin
      unique case (kind)
        tfrd_pkg::KIND_RX_BYTE: begin
          priority if (line_error_i) begin
            sticky_d = 1'b1;
          end else if (full) begin
            ovf = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wr_idx_d = (wr_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_q + IDX_W'(1);
            cnt_d    = cnt_q + IDX_W'(1);
            trk_ctl.byte_en = 1'b1;
          end
        end
        tfrd_pkg::KIND_READ: begin
          sticky_d = 1'b0;
          if (!empty) begin
            ram_re   = 1'b1;
            rd_idx_d = (rd_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_q + IDX_W'(1);
            cnt_d    = cnt_q - IDX_W'(1);
          end
        end
        tfrd_pkg::KIND_RESTART: begin
          trk_ctl.restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // fill level after this transaction, saturated
  assign cnt_ext  = 17'(cnt_d);
  assign fill_sat = (cnt_ext > 17'd255) ? tfrd_pkg::FILL_MAX : cnt_ext[7:0];

  // ring index and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
      sticky_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
      sticky_q <= sticky_d;
    end
  end

  // ring storage
  tfrd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // frame tracker
  tfrd_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (rx_byte_i),
    .ctl_i  (trk_ctl),
    .out_o  (trk_out)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rvalid_q <= ram_re;
      phase_q  <= trk_out.phase;
      event_q  <= trk_out.evt;
      fill_q   <= fill_sat;
      err_q    <= sticky_q;
      ovf_q    <= ovf;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rvalid_q ? ram_rdata : 8'd0;
  assign read_valid_o  = rvalid_q;
  assign frame_phase_o = phase_q;
  assign frame_event_o = event_q;
  assign fill_level_o  = fill_q;
  assign error_seen_o  = err_q;
  assign overflow_o    = ovf_q;

endmodule
`default_nettype wire
